/* design/u16u8_pkg.sv */
package u16u8_pkg;

   // mode register codes; the two unused codes behave as legacy pass
   localparam logic [2:0] MODE_LEGACY   = 3'd0;
   localparam logic [2:0] MODE_UTF8_BOM = 3'd1;
   localparam logic [2:0] MODE_LE_BOM   = 3'd2;
   localparam logic [2:0] MODE_BE_BOM   = 3'd3;
   localparam logic [2:0] MODE_LE       = 3'd4;
   localparam logic [2:0] MODE_BE       = 3'd5;

   // register word index (paddr[2]) of the mode register
   localparam logic REG_MODE = 1'b0;

   localparam int MAX_BYTES = 6;

   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   typedef struct packed {
      logic [1:0] skip_count;
      logic       half_unit_seen;
      logic [7:0] first_half_byte;
      logic       surrogate_pending;
      logic [9:0] pending_high_bits;
   } stream_state_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      len;
   } utf8_seq_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                count;
   } burst_type;

endpackage

/* design/u16u8_step.sv */
module u16u8_step (
   input  logic [2:0]                  mode,
   input  u16u8_pkg::stream_state_type state_cur,
   input  logic [7:0]                  data_byte,
   input  logic                        end_of_stream,
   output u16u8_pkg::stream_state_type state_nxt,
   output u16u8_pkg::burst_type        burst
);

   function automatic u16u8_pkg::utf8_seq_type encode(logic [20:0] cp);
      u16u8_pkg::utf8_seq_type s;
      s.bytes = '0;
      if (cp < 21'h80) begin
         s.len      = 3'd1;
         s.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         s.len      = 3'd2;
         s.bytes[0] = {3'b110, cp[10:6]};
         s.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         s.len      = 3'd3;
         s.bytes[0] = {4'b1110, cp[15:12]};
         s.bytes[1] = {2'b10, cp[11:6]};
         s.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         s.len      = 3'd4;
         s.bytes[0] = {5'b11110, cp[20:18]};
         s.bytes[1] = {2'b10, cp[17:12]};
         s.bytes[2] = {2'b10, cp[11:6]};
         s.bytes[3] = {2'b10, cp[5:0]};
      end
      return s;
   endfunction

   function automatic u16u8_pkg::burst_type append_seq(u16u8_pkg::burst_type acc,
                                                       u16u8_pkg::utf8_seq_type seq);
      logic [3:0]           pos;
      u16u8_pkg::burst_type r;
      r = acc;
      for (int k = 0; k < 4; k++) begin
         pos = {1'b0, acc.count} + 4'(k);
         if (3'(k) < seq.len && pos < 4'(u16u8_pkg::MAX_BYTES)) begin
            r.bytes[pos[2:0]] = seq.bytes[k];
         end
      end
      r.count = acc.count + seq.len;
      return r;
   endfunction

   logic [1:0]  bom_len;
   logic        wide;
   logic        little;
   logic [15:0] unit;
   logic        paired;
   u16u8_pkg::utf8_seq_type single;

   always_comb begin
      case (mode)
         u16u8_pkg::MODE_UTF8_BOM: bom_len = 2'd3;
         u16u8_pkg::MODE_LE_BOM,
         u16u8_pkg::MODE_BE_BOM:   bom_len = 2'd2;
         default:                  bom_len = 2'd0;
      endcase
      wide   = (mode == u16u8_pkg::MODE_LE_BOM) || (mode == u16u8_pkg::MODE_BE_BOM) ||
               (mode == u16u8_pkg::MODE_LE) || (mode == u16u8_pkg::MODE_BE);
      little = (mode == u16u8_pkg::MODE_LE_BOM) || (mode == u16u8_pkg::MODE_LE);
      unit   = little ? {data_byte, state_cur.first_half_byte}
                      : {state_cur.first_half_byte, data_byte};
      single          = '0;
      single.len      = 3'd1;
      single.bytes[0] = data_byte;
   end

   always_comb begin
      state_nxt = state_cur;
      burst     = '0;
      paired    = 1'b0;
      if (state_cur.skip_count < bom_len) begin
         state_nxt.skip_count = state_cur.skip_count + 2'd1;
      end else if (!wide) begin
         burst = append_seq(burst, single);
      end else if (!state_cur.half_unit_seen) begin
         state_nxt.half_unit_seen  = 1'b1;
         state_nxt.first_half_byte = data_byte;
      end else begin
         state_nxt.half_unit_seen  = 1'b0;
         state_nxt.first_half_byte = '0;
         if (state_cur.surrogate_pending) begin
            state_nxt.surrogate_pending = 1'b0;
            state_nxt.pending_high_bits = '0;
            if (unit[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
               paired = 1'b1;
               burst  = append_seq(burst, encode({1'b0, state_cur.pending_high_bits,
                                                  unit[9:0]} + 21'h10000));
            end else begin
               // unpaired high surrogate goes out alone
               burst = append_seq(burst, encode({5'b0, u16u8_pkg::HIGH_SURR_TAG,
                                                 state_cur.pending_high_bits}));
            end
         end
         if (!paired) begin
            if (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG) begin
               state_nxt.surrogate_pending = 1'b1;
               state_nxt.pending_high_bits = unit[9:0];
            end else begin
               burst = append_seq(burst, encode({5'b0, unit}));
            end
         end
      end
      if (end_of_stream) begin
         if (wide && state_nxt.surrogate_pending) begin
            burst = append_seq(burst, encode({5'b0, u16u8_pkg::HIGH_SURR_TAG,
                                              state_nxt.pending_high_bits}));
         end
         state_nxt = '0;
      end
   end

endmodule

/* design/utf16_to_utf8_decoder_core.sv */
// Byte stream to UTF-8 transcoder. Each raw byte enters on req_ (tlast marks the final byte
// of a stream) and the UTF-8 bytes it completes leave on rsp_, one per item, with tlast on
// the last byte caused by that input; bytes that complete nothing (BOM bytes, first half of
// a UTF-16 unit, high surrogates) produce no output. The mode register selects legacy pass,
// UTF-8 with BOM, UTF-16 LE/BE with or without BOM; write it only between streams while the
// block is idle. Input goes through an input register, one pass of combinational decode,
// and a six-byte burst register that drains one byte per cycle while rsp_tready is high;
// each input yields 0 to 6 bytes, and the next burst loads once the current one empties,
// so the output serialiser sets the rate. Output comes from the burst register, loaded from
// the input register via the decode. All decode state clears after an item with tlast set.
module utf16_to_utf8_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [2:0] mode_ff, mode_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_eos_ff, in_eos_in;
   u16u8_pkg::stream_state_type state_ff, state_in, state_nxt;
   u16u8_pkg::burst_type        burst_ff, burst_in, burst_nxt;

   logic csr_write;
   logic req_take;
   logic rsp_take;
   logic burst_free;
   logic in_take;

   u16u8_step u_step (
      .mode          (mode_ff),
      .state_cur     (state_ff),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .state_nxt     (state_nxt),
      .burst         (burst_nxt)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == u16u8_pkg::REG_MODE) ? {29'b0, mode_ff} : 32'b0;

   assign rsp_tvalid = (burst_ff.count != 3'd0);
   assign rsp_tdata  = burst_ff.bytes[0];
   assign rsp_tlast  = (burst_ff.count == 3'd1);
   assign rsp_take   = rsp_tvalid && rsp_tready;
   assign burst_free = !rsp_tvalid || (rsp_take && rsp_tlast);
   assign in_take    = in_valid_ff && burst_free;
   assign req_tready = !in_valid_ff || in_take;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write && csr_paddr[2] == u16u8_pkg::REG_MODE) begin
         mode_in = csr_pwdata[2:0];
      end

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eos_in   = in_eos_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_eos_in   = req_tlast;
      end else if (in_take) begin
         in_valid_in = 1'b0;
      end

      state_in = in_take ? state_nxt : state_ff;

      // advance the burst one byte per taken item, reload when it empties
      burst_in = burst_ff;
      if (rsp_take) begin
         for (int i = 0; i < u16u8_pkg::MAX_BYTES - 1; i++) begin
            burst_in.bytes[i] = burst_ff.bytes[i+1];
         end
         burst_in.count = burst_ff.count - 3'd1;
      end
      if (in_take) begin
         burst_in = burst_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= u16u8_pkg::MODE_LEGACY;
         in_valid_ff    <= 1'b0;
         state_ff       <= '0;
         burst_ff.count <= 3'd0;
      end else begin
         mode_ff        <= mode_in;
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         burst_ff.count <= burst_in.count;
      end
      in_byte_ff     <= in_byte_in;
      in_eos_ff      <= in_eos_in;
      burst_ff.bytes <= burst_in.bytes;
   end

endmodule

/* design/u16u8_chk.sv */
module u16u8_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   // hold a stalled output item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output item changed");

   // output empty after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid straight after reset");

   // input side free after reset
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready straight after reset");

   // mode register reads back what was written
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]
      |=> csr_paddr[2] || (csr_prdata[2:0] == $past(csr_pwdata[2:0])))
      else $error("mode register read back mismatch");

endmodule

bind utf16_to_utf8_decoder_core u16u8_chk u_chk (.*);

/* sim/tb_top.sv */
module tb_top;

   // mode codes left unused by the block; both fall back to legacy pass
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;
   localparam logic [2:0] MODE_ADDR     = {u16u8_pkg::REG_MODE, 2'b00};

   localparam int N_RANDOM       = 195;
   localparam int QUIET_TAIL     = 40;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 300;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } utf8_byte_type;

   typedef struct packed {
      logic [2:0]      mode;
      logic [7:0]      data_byte;
      logic            end_of_stream;
      logic            typed;
      logic [2:0]      n_bytes;
      logic [0:5][7:0] want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_stream
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;   // [7:0] out_byte
   logic        rsp_tlast;   // last_of_run
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   utf16_to_utf8_decoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // transcoder shadow state
   logic [2:0] cur_mode     = u16u8_pkg::MODE_LEGACY;
   logic [1:0] bom_dropped  = '0;
   logic       half_held    = 1'b0;
   logic [7:0] held_byte    = '0;
   logic       high_pending = 1'b0;
   logic [9:0] high_bits    = '0;
   logic [7:0] utf8_bytes[$];

   utf8_byte_type expected_utf8[$];
   logic [7:0] stream_bytes[$];

   bit send_gaps = 1'b0;
   bit recv_gaps = 1'b0;
   int errors = 0;
   int items_sent = 0;
   int bytes_checked = 0;
   int streams_ended = 0;
   int mode_writes = 0;

   function automatic void put_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         utf8_bytes.push_back(cp[7:0]);
      end else if (cp < 21'h800) begin
         utf8_bytes.push_back({3'b110, cp[10:6]});
         utf8_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         utf8_bytes.push_back({4'b1110, cp[15:12]});
         utf8_bytes.push_back({2'b10, cp[11:6]});
         utf8_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         utf8_bytes.push_back({5'b11110, cp[20:18]});
         utf8_bytes.push_back({2'b10, cp[17:12]});
         utf8_bytes.push_back({2'b10, cp[11:6]});
         utf8_bytes.push_back({2'b10, cp[5:0]});
      end
   endfunction

   function automatic void join_unit(input logic [15:0] unit);
      if (high_pending) begin
         high_pending = 1'b0;
         if (unit[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
            put_point(21'h10000 + {1'b0, high_bits, unit[9:0]});
            high_bits = '0;
            return;
         end
         // partner missing: flush the high half on its own
         put_point({5'd0, u16u8_pkg::HIGH_SURR_TAG, high_bits});
         high_bits = '0;
      end
      if (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG) begin
         high_pending = 1'b1;
         high_bits = unit[9:0];
      end else begin
         put_point({5'd0, unit});
      end
   endfunction

   // work out the UTF-8 bytes completed by one raw byte
   function automatic void transcode_byte(input logic [7:0] b, input logic eos);
      int  bom_len;
      bit  wide;
      bit  little;
      logic [15:0] unit;
      case (cur_mode)
         u16u8_pkg::MODE_UTF8_BOM: bom_len = 3;
         u16u8_pkg::MODE_LE_BOM,
         u16u8_pkg::MODE_BE_BOM:   bom_len = 2;
         default:                  bom_len = 0;
      endcase
      wide = cur_mode == u16u8_pkg::MODE_LE_BOM || cur_mode == u16u8_pkg::MODE_BE_BOM ||
             cur_mode == u16u8_pkg::MODE_LE || cur_mode == u16u8_pkg::MODE_BE;
      little = cur_mode == u16u8_pkg::MODE_LE_BOM || cur_mode == u16u8_pkg::MODE_LE;
      utf8_bytes.delete();
      if (int'(bom_dropped) < bom_len) begin
         bom_dropped = bom_dropped + 2'd1;
      end else if (!wide) begin
         utf8_bytes.push_back(b);
      end else if (!half_held) begin
         half_held = 1'b1;
         held_byte = b;
      end else begin
         unit = little ? {b, held_byte} : {held_byte, b};
         half_held = 1'b0;
         held_byte = '0;
         join_unit(unit);
      end
      if (eos) begin
         if (wide && high_pending)
            put_point({5'd0, u16u8_pkg::HIGH_SURR_TAG, high_bits});
         bom_dropped = '0;
         half_held = 1'b0;
         held_byte = '0;
         high_pending = 1'b0;
         high_bits = '0;
      end
   endfunction

   function automatic void push_unit(input logic [15:0] unit, input bit little);
      if (little) begin
         stream_bytes.push_back(unit[7:0]);
         stream_bytes.push_back(unit[15:8]);
      end else begin
         stream_bytes.push_back(unit[15:8]);
         stream_bytes.push_back(unit[7:0]);
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                            input logic [2:0] n, input logic [0:5][7:0] want);
      utf8_byte_type e;
      int k;
      @(negedge clock);
      if (send_gaps && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      do @(posedge clock); while (!req_tready);
      transcode_byte(b, eos);
      // a typed row replaces the predicted bytes but keeps the shadow state
      if (typed) begin
         utf8_bytes.delete();
         for (k = 0; k < int'(n); k++)
            utf8_bytes.push_back(want[k]);
      end
      for (k = 0; k < utf8_bytes.size(); k++) begin
         e.out_byte = utf8_bytes[k];
         e.last_of_run = (k == utf8_bytes.size() - 1);
         expected_utf8.push_back(e);
      end
      items_sent++;
      if (eos)
         streams_ended++;
   endtask

   // drain every expected byte, then let bytes that produce nothing clear the pipeline
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_utf8.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [2:0] m);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= {29'd0, m};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cur_mode = m;
      mode_writes++;
      // read back
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {29'd0, m}) begin
         $display("%0t: mode readback expected %h, got %h", $time, {29'd0, m}, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(negedge clock) begin : rsp_stall
      int stall_left;
      if (reset) begin
         stall_left = 0;
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (recv_gaps && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
      end
   end

   always @(posedge clock) begin : check_utf8
      utf8_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_utf8.size() == 0) begin
            $display("%0t: unexpected item, expected none, got byte %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = expected_utf8.pop_front();
            if (rsp_tdata !== want.out_byte || rsp_tlast !== want.last_of_run) begin
               $display("%0t: expected byte %h last %b, got byte %h last %b",
                        $time, want.out_byte, want.last_of_run, rsp_tdata, rsp_tlast);
               errors++;
            end
            bytes_checked++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet = 0;
      else
         quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d bytes still expected",
                  $time, quiet, expected_utf8.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows [29];
      dir_row_type row;
      logic [2:0]  m;
      logic [15:0] unit;
      logic [9:0]  r10;
      bit          wide;
      bit          little;
      bit          ends;
      int          i;
      int          total;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;

      // mode, byte, end of stream, typed, count, expected bytes in order
      dir_rows = '{
         {u16u8_pkg::MODE_LEGACY,   8'h00, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
         {u16u8_pkg::MODE_LEGACY,   8'hFF, 1'b1, 1'b1, 3'd1, 48'hFF_00_00_00_00_00},
         {MODE_SPARE_HI,            8'h80, 1'b1, 1'b1, 3'd1, 48'h80_00_00_00_00_00},
         {u16u8_pkg::MODE_UTF8_BOM, 8'hEF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_UTF8_BOM, 8'hBB, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_UTF8_BOM, 8'hBF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_UTF8_BOM, 8'h41, 1'b0, 1'b1, 3'd1, 48'h41_00_00_00_00_00},
         {u16u8_pkg::MODE_UTF8_BOM, 8'hC3, 1'b1, 1'b1, 3'd1, 48'hC3_00_00_00_00_00},
         {u16u8_pkg::MODE_LE_BOM,   8'hFF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'hFE, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'h00, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'hD8, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'h00, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'hDC, 1'b0, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
         {u16u8_pkg::MODE_LE_BOM,   8'hFF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE_BOM,   8'hDB, 1'b1, 1'b1, 3'd3, 48'hED_AF_BF_00_00_00},
         {u16u8_pkg::MODE_BE_BOM,   8'hFE, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'hFF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'hDF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'hFF, 1'b0, 1'b1, 3'd3, 48'hED_BF_BF_00_00_00},
         {u16u8_pkg::MODE_BE_BOM,   8'hDB, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'hFF, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'h4E, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'h00, 1'b0, 1'b0, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE_BOM,   8'h7F, 1'b1, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE,       8'h34, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_LE,       8'h12, 1'b0, 1'b0, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE,       8'h07, 1'b0, 1'b1, 3'd0, 48'h0},
         {u16u8_pkg::MODE_BE,       8'hFF, 1'b1, 1'b0, 3'd0, 48'h0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         if (row.mode != cur_mode) begin
            wait_idle();
            write_mode(row.mode);
         end
         send_byte(row.data_byte, row.end_of_stream, row.typed, row.n_bytes, row.want);
      end

      total = $size(dir_rows) + N_RANDOM;
      while (items_sent < total) begin
         case ($urandom_range(0, 9))
            0:       m = u16u8_pkg::MODE_LEGACY;
            1:       m = u16u8_pkg::MODE_UTF8_BOM;
            2:       m = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            3, 4:    m = u16u8_pkg::MODE_LE_BOM;
            5, 6:    m = u16u8_pkg::MODE_BE_BOM;
            7:       m = u16u8_pkg::MODE_LE;
            default: m = u16u8_pkg::MODE_BE;
         endcase
         wait_idle();
         write_mode(m);
         // no idling at all towards the end
         send_gaps = items_sent < total - QUIET_TAIL && $urandom_range(0, 3) != 0;
         recv_gaps = items_sent < total - QUIET_TAIL && $urandom_range(0, 3) != 0;

         wide = m == u16u8_pkg::MODE_LE_BOM || m == u16u8_pkg::MODE_BE_BOM ||
                m == u16u8_pkg::MODE_LE || m == u16u8_pkg::MODE_BE;
         little = m == u16u8_pkg::MODE_LE_BOM || m == u16u8_pkg::MODE_LE;
         stream_bytes.delete();
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12)) stream_bytes.push_back(8'($urandom));
         end else begin
            if ($urandom_range(0, 4) != 0) begin
               if (m == u16u8_pkg::MODE_UTF8_BOM) begin
                  stream_bytes.push_back(8'hEF);
                  stream_bytes.push_back(8'hBB);
                  stream_bytes.push_back(8'hBF);
               end else if (m == u16u8_pkg::MODE_LE_BOM || m == u16u8_pkg::MODE_BE_BOM) begin
                  push_unit(16'hFEFF, little);
               end
            end
            repeat ($urandom_range(1, 8)) begin
               if (!wide) begin
                  stream_bytes.push_back(8'($urandom));
               end else begin
                  r10 = 10'($urandom);
                  case ($urandom_range(0, 9))
                     0, 1, 2: unit = 16'($urandom_range(0, 16'h7F));
                     3:       unit = 16'($urandom_range(16'h80, 16'h7FF));
                     4:       unit = $urandom_range(0, 1) ?
                                     16'($urandom_range(16'h800, 16'hD7FF)) :
                                     16'($urandom_range(16'hE000, 16'hFFFF));
                     5, 6: begin
                        push_unit({u16u8_pkg::HIGH_SURR_TAG, r10}, little);
                        unit = {u16u8_pkg::LOW_SURR_TAG, 10'($urandom)};
                     end
                     7:       unit = {u16u8_pkg::HIGH_SURR_TAG, r10};
                     8:       unit = {u16u8_pkg::LOW_SURR_TAG, r10};
                     default: unit = 16'($urandom);
                  endcase
                  push_unit(unit, little);
               end
            end
            // odd trailing byte
            if (wide && $urandom_range(0, 5) == 0)
               stream_bytes.push_back(8'($urandom));
         end
         // leave some streams open so the next mode write lands mid-stream
         ends = $urandom_range(0, 5) != 0;
         for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], ends && i == stream_bytes.size() - 1,
                      1'b0, 3'd0, 48'h0);
      end

      wait_idle();
      $display("Sent %0d raw bytes under %0d mode writes, %0d streams closed",
               items_sent, mode_writes, streams_ended);
      $display("Checked %0d UTF-8 bytes, %0d mismatches", bytes_checked, errors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
